[hw/rtl/midi_bsp_pkg.sv]
// ============================================================================
// MIDI byte stream parser package
// Shared types, byte codes and the status length table for the parser.
// ============================================================================
package midi_bsp_pkg;

    // Byte codes that steer the parser.
    localparam logic [7:0] SYSEX_START    = 8'hF0;
    localparam logic [7:0] SYSEX_END      = 8'hF7;
    localparam logic [7:0] REALTIME_FIRST = 8'hF8;

    // Width of the packed result word on the output stream.
    localparam int unsigned RESULT_W = 40;

    // One accepted input byte with its list marker.
    typedef struct packed {
        logic       first_of_list;
        logic [7:0] data_byte;
    } t_item;

    // One result, as handed from the parser core to the output register.
    typedef struct packed {
        logic       overrun;
        logic [7:0] clock_byte;
        logic       clock_valid;
        logic [7:0] message_third;
        logic [7:0] message_second;
        logic [7:0] message_first;
        logic [1:0] message_length;
        logic       message_valid;
    } t_result;

    // Message length for a status byte.
    function automatic logic [1:0] length_of(input logic [7:0] s);
        logic [1:0] len;
        case (s[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd3;
            4'hC, 4'hD:                   len = 2'd2;
            4'hF: begin
                case (s[3:0])
                    4'h0, 4'h2:                   len = 2'd3;
                    4'h6, 4'h7, 4'h8, 4'hA, 4'hB,
                    4'hC, 4'hE, 4'hF:             len = 2'd1;
                    default:                      len = 2'd2;
                endcase
            end
            default: len = 2'd2;
        endcase
        return len;
    endfunction

endpackage

[hw/rtl/midi_byte_stream_parser.sv]
// ============================================================================
// MIDI byte stream parser
// Rebuilds MIDI messages from a byte stream, one byte per transfer.
// ============================================================================
//  Channel   Direction  Handshake                       Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tdata: data_byte, tuser: first_of_list
//  m_axis    out        m_axis_tvalid / m_axis_tready   tdata: packed result word
//  cfg       in         i_cfg_we                        i_cfg_wdata: clock_forward_enable
//
//  Each byte passes an input register and a result register; one byte per
//  cycle is sustained while the output is not stalled.
//  Reset is synchronous, clears the parser state and empties both registers;
//  forwarding comes up enabled. A stalled output holds its result while the
//  input register still takes one more byte.
// ============================================================================
module midi_byte_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tuser,  // [0] first_of_list
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] message_valid, [2:1] message_length, [10:3] message_first,
    // [18:11] message_second, [26:19] message_third, [27] clock_valid,
    // [35:28] clock_byte, [36] overrun, [39:37] zero
    output logic [39:0] m_axis_tdata
);

    logic                  r_clock_forward_enable;
    logic                  r_in_valid;
    midi_bsp_pkg::t_item   r_in_item;
    logic                  r_out_valid;
    midi_bsp_pkg::t_result r_out_result;
    midi_bsp_pkg::t_result core_result;
    logic                  advance;

    // The input byte moves on when the result register is free or draining.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_forward_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_clock_forward_enable <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.data_byte     <= s_axis_tdata;
            r_in_item.first_of_list <= s_axis_tuser;
        end
    end

    midi_bsp_core u_core (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_advance              (advance),
        .i_clock_forward_enable (r_clock_forward_enable),
        .i_item                 (r_in_item),
        .o_result               (core_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(midi_bsp_pkg::RESULT_W - $bits(midi_bsp_pkg::t_result)){1'b0}},
                            r_out_result};

endmodule

[hw/rtl/midi_bsp_core.sv]
// ============================================================================
// MIDI byte stream parser core
// Holds the parser state and works out the result for one byte per cycle while i_advance is high.
// ============================================================================
module midi_bsp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic                 i_clock_forward_enable,
    input  midi_bsp_pkg::t_item  i_item,
    output midi_bsp_pkg::t_result o_result
);

    // Parser state.
    logic [7:0] r_running_status;
    logic [1:0] r_running_length;
    logic [7:0] r_buf0;
    logic [7:0] r_buf1;
    logic [7:0] r_buf2;
    logic [1:0] r_fill;
    logic [1:0] r_expected;
    logic       r_in_message;
    logic       r_in_sysex;

    logic [7:0] n_running_status;
    logic [1:0] n_running_length;
    logic [7:0] n_buf0;
    logic [7:0] n_buf1;
    logic [7:0] n_buf2;
    logic [1:0] n_fill;
    logic [1:0] n_expected;
    logic       n_in_message;
    logic       n_in_sysex;

    logic [7:0] b;
    logic       dropped;
    logic       clk_hit;
    logic       emit;

    assign b = i_item.data_byte;

    // Next state and result for the byte in the input register.
    always_comb begin
        n_running_status = r_running_status;
        n_running_length = r_running_length;
        n_buf0           = r_buf0;
        n_buf1           = r_buf1;
        n_buf2           = r_buf2;
        n_fill           = r_fill;
        n_expected       = r_expected;
        n_in_message     = r_in_message;
        n_in_sysex       = r_in_sysex;
        dropped          = 1'b0;

        // A new packet list starts from a clean parser.
        if (i_item.first_of_list) begin
            n_running_status = '0;
            n_running_length = '0;
            n_buf0           = '0;
            n_buf1           = '0;
            n_buf2           = '0;
            n_fill           = '0;
            n_expected       = '0;
            n_in_message     = 1'b0;
            n_in_sysex       = 1'b0;
        end

        clk_hit = (b >= midi_bsp_pkg::REALTIME_FIRST) && i_clock_forward_enable;

        if (b[7] && (b != midi_bsp_pkg::SYSEX_END)) begin
            // Status byte opens a new message.
            n_expected   = midi_bsp_pkg::length_of(b);
            n_in_message = 1'b1;
            n_buf0       = b;
            n_fill       = 2'd1;
            n_in_sysex   = (b == midi_bsp_pkg::SYSEX_START);
            if (b < midi_bsp_pkg::REALTIME_FIRST) begin
                n_running_status = b;
                n_running_length = n_expected;
            end
        end else begin
            // Data byte or sysex end: open a sysex chunk or a running status message.
            if (!n_in_message) begin
                n_in_message = 1'b1;
                if (n_in_sysex) begin
                    n_fill     = 2'd0;
                    n_expected = 2'd3;
                end else begin
                    n_expected = n_running_length;
                    n_buf0     = n_running_status;
                    n_fill     = 2'd1;
                end
            end
            if (n_fill == 2'd3) begin
                dropped = 1'b1;
            end else begin
                case (n_fill)
                    2'd0:    n_buf0 = b;
                    2'd1:    n_buf1 = b;
                    default: n_buf2 = b;
                endcase
                n_fill = n_fill + 2'd1;
                if (b == midi_bsp_pkg::SYSEX_END) begin
                    n_in_sysex = 1'b0;
                    n_expected = n_fill;
                end
            end
        end

        emit = n_in_message && (n_expected == n_fill);

        o_result                = '0;
        o_result.clock_valid    = clk_hit;
        o_result.clock_byte     = clk_hit ? b : 8'd0;
        o_result.overrun        = dropped;
        if (emit) begin
            o_result.message_valid  = 1'b1;
            o_result.message_length = n_expected;
            o_result.message_first  = (n_expected != 2'd0) ? n_buf0 : 8'd0;
            o_result.message_second = (n_expected >= 2'd2) ? n_buf1 : 8'd0;
            o_result.message_third  = (n_expected == 2'd3) ? n_buf2 : 8'd0;
            n_in_message            = 1'b0;
            n_fill                  = 2'd0;
        end
    end

    // State update when the byte moves on to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_status <= '0;
            r_running_length <= '0;
            r_buf0           <= '0;
            r_buf1           <= '0;
            r_buf2           <= '0;
            r_fill           <= '0;
            r_expected       <= '0;
            r_in_message     <= 1'b0;
            r_in_sysex       <= 1'b0;
        end else if (i_advance) begin
            r_running_status <= n_running_status;
            r_running_length <= n_running_length;
            r_buf0           <= n_buf0;
            r_buf1           <= n_buf1;
            r_buf2           <= n_buf2;
            r_fill           <= n_fill;
            r_expected       <= n_expected;
            r_in_message     <= n_in_message;
            r_in_sysex       <= n_in_sysex;
        end
    end

endmodule

[hw/rtl/midi_bsp_checker.sv]
// ============================================================================
// MIDI byte stream parser checker
// Port-level checks on the result stream, bound to the top level.
// ============================================================================
module midi_bsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // A stalled result transfer holds its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // With no message, the message fields are all zero.
    a_no_msg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[26:1] == 26'd0)
        else $error("message fields set without a message");

    // A message always carries at least one byte.
    a_msg_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] != 2'd0)
        else $error("message with zero length");

    // Only realtime bytes reach the clock, and only when flagged.
    a_clock_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[27] ? (m_axis_tdata[35:31] == 5'h1F)
                                            : (m_axis_tdata[35:28] == 8'd0)))
        else $error("clock byte inconsistent with clock flag");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind midi_byte_stream_parser midi_bsp_checker u_midi_bsp_checker (.*);
